// ===== rtl/lrcm_pkg.sv =====
package lrcm_pkg;

    localparam int SampleW  = 16;
    localparam int RateW    = 18;
    localparam int RemW     = 19;
    localparam int ChW      = 2;
    localparam int CfgIdxW  = 2;
    localparam int AccW     = 36;
    localparam int NumW     = 37;
    localparam int DvdW     = 50;
    localparam int QuotW    = 32;
    localparam int DivSteps = 32;
    localparam int DivCntW  = 5;
    localparam int Lanes    = 2;

    localparam logic [RateW-1:0] RateMin   = 18'd8000;
    localparam logic [RateW-1:0] RateMax   = 18'd192000;
    localparam logic [RateW-1:0] RateReset = 18'd48000;
    localparam logic [ChW-1:0]   ChReset   = 2'd2;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_IN_RATE  = 2'd0,
        CFG_OUT_RATE = 2'd1,
        CFG_IN_CH    = 2'd2,
        CFG_OUT_CH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_CHECK,
        S_MUL0,
        S_MUL1,
        S_PREP,
        S_DIV,
        S_OUT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic capture;
        logic ends_pass1;
        logic mul0;
        logic mul1;
        logic prep;
        logic div_step;
        logic make_result;
        logic push;
        logic push_last;
        logic rem_adv;
        logic rem_wrap;
        logic hold_new;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic eq;
        logic passthru;
        logic fin;
        logic rem_lt;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/lrcm_in_if.sv =====
interface lrcm_in_if import lrcm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] left_sample;
    logic signed [SampleW-1:0] right_sample;
    logic                      final_frame;

    modport source (output valid, left_sample, right_sample, final_frame, input ready);
    modport sink (input valid, left_sample, right_sample, final_frame, output ready);
endinterface

// ===== rtl/lrcm_out_if.sv =====
interface lrcm_out_if import lrcm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] out_left;
    logic signed [SampleW-1:0] out_right;
    logic                      run_end;
    logic                      clip_end;

    modport source (output valid, out_left, out_right, run_end, clip_end, input ready);
    modport sink (input valid, out_left, out_right, run_end, clip_end, output ready);
endinterface

// ===== rtl/linear_resample_channel_map_top.sv =====
// Linear-interpolation sample rate converter with channel mapping. Takes one
// PCM16 frame (mono or stereo) per input transfer and emits device frames at
// positions n*in_rate/out_rate, interpolated between the held frame and the new
// one, scaled by 32767/32768 and truncated toward zero; equal rates and channel
// counts pass samples through unchanged. A frame flagged final_frame also flushes
// the interval toward silence and starts a new clip. Rates saturate to
// 8000..192000 and out_rate to 24x in_rate. An input transfer is taken only
// from idle; a result passes a loop check (none at equal rates), two multiply
// states, a setup state, the bit-serial divide by out_rate and an output
// state, and pure pass-through goes straight to output. One input transfer
// yields up to 48 results. One result is buffered ahead of the output
// register, so the next input is accepted while the last result still waits.
// Configuration must be written only while idle; the block does not enforce
// it.
module linear_resample_channel_map_top import lrcm_pkg::*; #(
    parameter int MAX_UPSAMPLE = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [RateW-1:0]   i_cfg_data,
    lrcm_in_if.sink            i_src,
    lrcm_out_if.source         o_dst
);
    t_cmd    cmd;
    t_status status;

    // sequencing: interval loops, per-result steps, held-frame bookkeeping
    lrcm_ctrl #(
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_src.valid),
        .o_in_ready (i_src.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // arithmetic, state and output register
    lrcm_datapath #(
        .MAX_UPSAMPLE (MAX_UPSAMPLE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_left      (i_src.left_sample),
        .i_right     (i_src.right_sample),
        .i_final     (i_src.final_frame),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_dst.ready),
        .o_out_valid (o_dst.valid),
        .o_out_left  (o_dst.out_left),
        .o_out_right (o_dst.out_right),
        .o_run_end   (o_dst.run_end),
        .o_clip_end  (o_dst.clip_end)
    );

    // one item at a time: after a transfer the input closes
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_src.valid && i_src.ready) |=> !i_src.ready)
        else $error("input accepted while an item is in work");

    // a result is never pushed over one still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> status.out_free)
        else $error("result pushed into a full output register");

    // the end of a clip is always the end of a step
    a_clip_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dst.valid && o_dst.clip_end) |-> o_dst.run_end)
        else $error("clip_end without run_end");
endmodule

// ===== rtl/lrcm_ctrl.sv =====
module lrcm_ctrl import lrcm_pkg::*; #(
    parameter int MAX_UPSAMPLE = 24
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    localparam int CntW = $clog2(MAX_UPSAMPLE + 1);

    t_state               r_state, n_state;
    logic                 r_held_valid, n_held_valid;
    logic                 r_pass, n_pass;
    logic                 r_pend_valid, n_pend_valid;
    logic [CntW-1:0]      r_cnt, n_cnt;
    logic [DivCntW-1:0]   r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held_valid <= 1'b0;
            r_pass       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_cnt        <= '0;
            r_bit        <= '0;
        end else begin
            r_state      <= n_state;
            r_held_valid <= n_held_valid;
            r_pass       <= n_pass;
            r_pend_valid <= n_pend_valid;
            r_cnt        <= n_cnt;
            r_bit        <= n_bit;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_held_valid = r_held_valid;
        n_pass       = r_pass;
        n_pend_valid = r_pend_valid;
        n_cnt        = r_cnt;
        n_bit        = r_bit;
        o_cmd        = '0;
        o_cmd.ends_pass1 = r_pass;
        o_in_ready   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_cnt = '0;
                if (i_status.eq) begin
                    n_pass  = 1'b1;
                    n_state = i_status.passthru ? S_OUT : S_MUL0;
                end else if (r_held_valid) begin
                    n_pass  = 1'b0;
                    n_state = S_CHECK;
                end else if (i_status.fin) begin
                    n_pass  = 1'b1;
                    n_state = S_CHECK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CHECK: begin
                if (i_status.rem_lt && (r_cnt < CntW'(MAX_UPSAMPLE))) begin
                    n_state = S_MUL0;
                end else begin
                    o_cmd.rem_wrap = 1'b1;
                    if (!r_pass && i_status.fin) begin
                        n_pass = 1'b1;
                        n_cnt  = '0;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_bit   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit = r_bit + 1'b1;
                if (r_bit == DivCntW'(DivSteps - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_pend_valid || i_status.out_free) begin
                    o_cmd.push        = r_pend_valid;
                    o_cmd.make_result = 1'b1;
                    n_pend_valid      = 1'b1;
                    if (i_status.eq) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.rem_adv = 1'b1;
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end
            S_FIN: begin
                if (!r_pend_valid || i_status.out_free) begin
                    o_cmd.push      = r_pend_valid;
                    o_cmd.push_last = r_pend_valid;
                    n_pend_valid    = 1'b0;
                    if (i_status.fin) begin
                        o_cmd.clear  = 1'b1;
                        n_held_valid = 1'b0;
                    end else if (!i_status.eq) begin
                        o_cmd.hold_new = 1'b1;
                        n_held_valid   = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/lrcm_datapath.sv =====
module lrcm_datapath import lrcm_pkg::*; #(
    parameter int MAX_UPSAMPLE = 24
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CfgIdxW-1:0]        i_cfg_index,
    input  logic [RateW-1:0]          i_cfg_data,
    input  logic signed [SampleW-1:0] i_left,
    input  logic signed [SampleW-1:0] i_right,
    input  logic                      i_final,
    input  t_cmd                      i_cmd,
    output t_status                   o_status,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic signed [SampleW-1:0] o_out_left,
    output logic signed [SampleW-1:0] o_out_right,
    output logic                      o_run_end,
    output logic                      o_clip_end
);
    localparam int LimW = RateW + $clog2(MAX_UPSAMPLE + 1);

    // configuration
    logic [RateW-1:0] r_in_rate, r_out_rate;
    logic [ChW-1:0]   r_in_ch, r_out_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate  <= RateReset;
            r_out_rate <= RateReset;
            r_in_ch    <= ChReset;
            r_out_ch   <= ChReset;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IN_RATE:  r_in_rate  <= i_cfg_data;
                CFG_OUT_RATE: r_out_rate <= i_cfg_data;
                CFG_IN_CH:    r_in_ch    <= i_cfg_data[ChW-1:0];
                CFG_OUT_CH:   r_out_ch   <= i_cfg_data[ChW-1:0];
                default: ;
            endcase
        end
    end

    // effective rates, resolved per transfer
    logic [RateW-1:0] ir_c, or_c, or_eff;
    logic [LimW-1:0]  lim;
    logic             in2, out2;

    always_comb begin
        ir_c = (r_in_rate < RateMin) ? RateMin : ((r_in_rate > RateMax) ? RateMax : r_in_rate);
        or_c = (r_out_rate < RateMin) ? RateMin :
               ((r_out_rate > RateMax) ? RateMax : r_out_rate);
        lim  = LimW'(ir_c) * LimW'(MAX_UPSAMPLE);
        or_eff = (LimW'(or_c) > lim) ? lim[RateW-1:0] : or_c;
        in2  = r_in_ch[1];
        out2 = r_out_ch[1];
    end

    logic signed [SampleW-1:0] r_new [Lanes];
    logic signed [SampleW-1:0] r_held [Lanes];
    logic [RateW-1:0]          r_ir, r_orate;
    logic                      r_eq, r_passthru, r_sum, r_mono, r_fin;
    logic [RemW-1:0]           r_rem;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_new[0]   <= i_left;
            r_new[1]   <= in2 ? i_right : i_left;
            r_ir       <= ir_c;
            r_orate    <= or_eff;
            r_eq       <= (ir_c == or_eff);
            r_passthru <= (ir_c == or_eff) && (in2 == out2);
            r_sum      <= in2 && !out2;
            r_mono     <= !out2;
            r_fin      <= i_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_cmd.clear) begin
            r_rem <= '0;
        end else if (i_cmd.rem_adv) begin
            r_rem <= r_rem + RemW'(r_ir);
        end else if (i_cmd.rem_wrap) begin
            r_rem <= (r_rem >= RemW'(r_orate)) ? r_rem - RemW'(r_orate) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Lanes; k++) begin
            if (i_cmd.clear) begin
                r_held[k] <= '0;
            end else if (i_cmd.hold_new) begin
                r_held[k] <= r_new[k];
            end
        end
    end

    // interpolation: acc = a*(orate-rem) + b*rem, one product per lane per cycle
    logic [RemW:0]             w1, w0, wsel;
    logic signed [SampleW-1:0] samp [Lanes];
    logic signed [AccW-1:0]    prod [Lanes];
    logic signed [AccW-1:0]    r_acc [Lanes];

    always_comb begin
        w1   = r_eq ? '0 : {1'b0, r_rem};
        w0   = (RemW+1)'(r_orate) - w1;
        wsel = i_cmd.mul1 ? w1 : w0;
        for (int k = 0; k < Lanes; k++) begin
            if (i_cmd.mul1) begin
                samp[k] = i_cmd.ends_pass1 ? '0 : r_new[k];
            end else begin
                samp[k] = i_cmd.ends_pass1 ? r_new[k] : r_held[k];
            end
            prod[k] = AccW'(samp[k]) * AccW'($signed(wsel));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Lanes; k++) begin
            if (i_cmd.mul0) begin
                r_acc[k] <= prod[k];
            end else if (i_cmd.mul1) begin
                r_acc[k] <= r_acc[k] + prod[k];
            end
        end
    end

    // magnitude times 32767, then long division by orate, one bit per cycle
    logic signed [NumW-1:0] num [Lanes];
    logic [NumW-1:0]        mag [Lanes];
    logic [DvdW-1:0]        dvd [Lanes];
    logic [RemW-1:0]        trial [Lanes];
    logic                   ge [Lanes];
    logic [RateW-1:0]       r_part [Lanes];
    logic [QuotW-1:0]       r_q [Lanes];
    logic                   r_neg [Lanes];

    always_comb begin
        num[0] = r_sum ? (NumW'(r_acc[0]) + NumW'(r_acc[1])) : NumW'(r_acc[0]);
        num[1] = NumW'(r_acc[1]);
        for (int k = 0; k < Lanes; k++) begin
            mag[k]   = num[k][NumW-1] ? NumW'(-num[k]) : NumW'(num[k]);
            dvd[k]   = (DvdW'(mag[k]) << 15) - DvdW'(mag[k]);
            trial[k] = {r_part[k], r_q[k][QuotW-1]};
            ge[k]    = trial[k] >= RemW'(r_orate);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Lanes; k++) begin
            if (i_cmd.prep) begin
                r_neg[k]  <= num[k][NumW-1];
                r_part[k] <= dvd[k][DvdW-1:QuotW];
                r_q[k]    <= dvd[k][QuotW-1:0];
            end else if (i_cmd.div_step) begin
                r_part[k] <= ge[k] ? RateW'(trial[k] - RemW'(r_orate)) : trial[k][RateW-1:0];
                r_q[k]    <= {r_q[k][QuotW-2:0], ge[k]};
            end
        end
    end

    logic [SampleW-1:0]        qs [Lanes];
    logic signed [SampleW-1:0] res [Lanes];

    always_comb begin
        for (int k = 0; k < Lanes; k++) begin
            qs[k]  = r_sum ? r_q[k][SampleW+15:16] : r_q[k][SampleW+14:15];
            res[k] = r_neg[k] ? -$signed(qs[k]) : $signed(qs[k]);
        end
    end

    // pending result and output register
    logic signed [SampleW-1:0] r_pend_l, r_pend_r;
    logic                      r_out_valid;
    logic                      out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.make_result) begin
            r_pend_l <= r_passthru ? r_new[0] : res[0];
            r_pend_r <= r_mono ? '0 : (r_passthru ? r_new[1] : res[1]);
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            o_out_left  <= r_pend_l;
            o_out_right <= r_pend_r;
            o_run_end   <= i_cmd.push_last;
            o_clip_end  <= i_cmd.push_last && r_fin;
        end
    end

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_status.eq       = r_eq;
        o_status.passthru = r_passthru;
        o_status.fin      = r_fin;
        o_status.rem_lt   = r_rem < RemW'(r_orate);
        o_status.out_free = out_free;
    end
endmodule

// ===== verif/linear_resample_channel_map_top_tb.sv =====
module linear_resample_channel_map_top_tb;
    import lrcm_pkg::*;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               run_end;
        logic               clip_end;
    } t_frame;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index = CFG_IN_RATE;
    logic [RateW-1:0] i_cfg_data = '0;

    lrcm_in_if src_if ();
    lrcm_out_if dst_if ();

    linear_resample_channel_map_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_src      (src_if.sink),
        .o_dst      (dst_if.source)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow of the configuration registers and converter state.
    logic [17:0] cfg_in_rate, cfg_out_rate;
    logic [1:0]  cfg_in_ch, cfg_out_ch;
    int          held_l, held_r;
    bit          held_ok;
    int unsigned phase_rem;

    t_frame frames_due[$];
    int     n_errors = 0;
    int     n_results = 0;
    int     n_items = 0;
    int     n_clips = 0;
    bit     idle_on = 1'b1;   // random gaps on both sides
    bit     hold_sink = 1'b0; // long receiver stall

    task automatic report_mismatch(input string what);
        $display("mismatch: %s at %0t", what, $time);
        n_errors++;
    endtask

    function automatic int unsigned sat_rate(input logic [17:0] v);
        if (v < 18'd8000) return 8000;
        if (v > 18'd192000) return 192000;
        return v;
    endfunction

    function automatic int unsigned sat_ch(input logic [1:0] v);
        if (v == 2'd0) return 1;
        if (v == 2'd3) return 2;
        return v;
    endfunction

    // One interpolated device frame; truncation toward zero as in C.
    function automatic t_frame interp(input int l0, r0, l1, r1,
                                      input int unsigned rem, orate, ich, och);
        longint w1, w0, nl, nr, den;
        t_frame f;
        w1 = rem;
        w0 = longint'(orate) - w1;
        nl = l0 * w0 + l1 * w1;
        nr = r0 * w0 + r1 * w1;
        den = longint'(orate) * 32768;
        if (ich == 1) nr = nl;
        f.right = '0;
        if (och == 2) begin
            f.left = 16'((nl * 32767) / den);
            f.right = 16'((nr * 32767) / den);
        end else if (ich == 2) begin
            f.left = 16'(((nl + nr) * 32767) / (den * 2));
        end else begin
            f.left = 16'((nl * 32767) / den);
        end
        f.run_end = 1'b0;
        f.clip_end = 1'b0;
        return f;
    endfunction

    function automatic void clear_clip();
        held_l = 0;
        held_r = 0;
        held_ok = 1'b0;
        phase_rem = 0;
    endfunction

    // Resampler prediction for one source frame; pushes expected device frames.
    function automatic void predict_frames(input logic signed [15:0] ls, rs,
                                           input logic fin);
        int unsigned ir, orate, ich, och, rem, cnt;
        int l, r, al, ar, bl, br, n0;
        t_frame f;
        ir = sat_rate(cfg_in_rate);
        orate = sat_rate(cfg_out_rate);
        ich = sat_ch(cfg_in_ch);
        och = sat_ch(cfg_out_ch);
        l = ls;
        r = (ich == 2) ? int'(rs) : l;
        n0 = frames_due.size();
        if (orate > ir * 24) orate = ir * 24;
        if (ir == orate) begin
            if (ich == och) begin
                f.left = 16'(l);
                f.right = (och == 2) ? 16'(r) : 16'sd0;
            end else begin
                f = interp(l, r, 0, 0, 0, orate, ich, och);
            end
            f.run_end = 1'b1;
            f.clip_end = fin;
            frames_due.push_back(f);
            if (fin) clear_clip();
            return;
        end
        for (int pass = 0; pass < 2; pass++) begin
            rem = phase_rem & 32'h7FFFF;
            cnt = 0;
            if (pass == 0) begin
                if (!held_ok) continue;
                al = held_l; ar = held_r; bl = l; br = r;
            end else begin
                if (!fin) break;
                al = l; ar = r; bl = 0; br = 0;
            end
            while (rem < orate && cnt < 24) begin
                frames_due.push_back(interp(al, ar, bl, br, rem, orate, ich, och));
                cnt++;
                rem += ir;
            end
            rem = (rem >= orate) ? rem - orate : 0;
            phase_rem = rem & 32'h7FFFF;
        end
        held_l = l;
        held_r = r;
        held_ok = 1'b1;
        if (frames_due.size() > n0) begin
            frames_due[$].run_end = 1'b1;
            frames_due[$].clip_end = fin;
        end
        if (fin) clear_clip();
    endfunction

    // Result checker and receiver ready; all sampling at the rising edge.
    int sink_gap = 0;
    always @(posedge i_clk) begin
        t_frame e;
        if (i_rst_n && dst_if.valid && dst_if.ready) begin
            n_results++;
            if (frames_due.size() == 0) begin
                report_mismatch("unexpected transfer");
            end else begin
                e = frames_due.pop_front();
                if (dst_if.out_left !== e.left)
                    report_mismatch($sformatf("out_left %0d want %0d",
                                              dst_if.out_left, e.left));
                if (dst_if.out_right !== e.right)
                    report_mismatch($sformatf("out_right %0d want %0d",
                                              dst_if.out_right, e.right));
                if (dst_if.run_end !== e.run_end) report_mismatch("run_end");
                if (dst_if.clip_end !== e.clip_end) report_mismatch("clip_end");
            end
        end
        if (hold_sink) begin
            dst_if.ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            dst_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_gap <= $urandom_range(1, 12) - 1;
            dst_if.ready <= 1'b0;
        end else begin
            dst_if.ready <= 1'b1;
        end
    end

    initial begin
        dst_if.ready = 1'b0;
        src_if.valid = 1'b0;
        src_if.left_sample = '0;
        src_if.right_sample = '0;
        src_if.final_frame = 1'b0;
    end

    // Offer one frame and hold it until the transfer; predict on acceptance.
    // Valid stays high into the next frame unless a gap or a drain follows.
    task automatic send_frame(input logic signed [15:0] ls, rs, input logic fin);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            src_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        src_if.valid <= 1'b1;
        src_if.left_sample <= ls;
        src_if.right_sample <= rs;
        src_if.final_frame <= fin;
        do @(posedge i_clk); while (!src_if.ready);
        predict_frames(ls, rs, fin);
        n_items++;
        if (fin) n_clips++;
    endtask

    task automatic drain();
        src_if.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        // a step may still be running when it ends with no result
        repeat (2000) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [17:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_IN_RATE:  cfg_in_rate = val;
            CFG_OUT_RATE: cfg_out_rate = val;
            CFG_IN_CH:    cfg_in_ch = val[1:0];
            CFG_OUT_CH:   cfg_out_ch = val[1:0];
            default: ;
        endcase
    endtask

    task automatic set_format(input logic [17:0] ir, orr, input logic [1:0] ic, oc);
        drain();
        write_reg(CFG_IN_RATE, ir);
        write_reg(CFG_OUT_RATE, orr);
        write_reg(CFG_IN_CH, {16'd0, ic});
        write_reg(CFG_OUT_CH, {16'd0, oc});
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rnd_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Short clip of random frames, the last one final.
    task automatic send_clip(input int len);
        for (int i = 0; i < len; i++)
            send_frame(rnd_sample(), rnd_sample(), i == len - 1);
    endtask

    // Directed: extremes, pass-through, lone final frame, channel mapping.
    task automatic test_directed();
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7FFF, 1'b1);
        set_format(18'd8000, 18'd192000, 2'd2, 2'd2);
        send_frame(16'sh7FFF, 16'sh7FFF, 1'b1);
        send_frame(16'sh8000, 16'sh8000, 1'b0);
        send_frame(16'sh7FFF, 16'sh8000, 1'b0);
        send_frame(16'sh0000, 16'shFFFF, 1'b1);
        set_format(18'd192000, 18'd8000, 2'd2, 2'd1);
        for (int i = 0; i < 6; i++) send_frame(16'sh7FFF, 16'sh7FFF, i == 5);
        send_frame(16'sh1234, 16'sh8000, 1'b1);
        set_format(18'd44100, 18'd44100, 2'd1, 2'd2);
        send_frame(16'sh8000, 16'sh1111, 1'b0);
        send_frame(16'sh7FFF, 16'sh2222, 1'b1);
        set_format(18'h3FFFF, 18'd0, 2'd0, 2'd3);
        send_clip(3);
        set_format(18'd1000, 18'h3FFFF, 2'd3, 2'd0);
        send_clip(3);
    endtask

    // Random formats, short clips; one config change lands mid-clip.
    task automatic test_random(input int items);
        int sent;
        logic [17:0] rates[6] = '{18'd8000, 18'd11025, 18'd44100, 18'd48000,
                                  18'd96000, 18'd192000};
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(0, 9) == 0)
                set_format(18'($urandom), 18'($urandom), 2'($urandom), 2'($urandom));
            else if ($urandom_range(0, 2) == 0)
                set_format(rates[$urandom_range(0, 5)], rates[$urandom_range(0, 5)],
                           2'($urandom), 2'($urandom));
            else
                set_format(18'($urandom_range(8000, 192000)),
                           18'($urandom_range(8000, 192000)),
                           2'($urandom_range(1, 2)), 2'($urandom_range(1, 2)));
            for (int k = 0; k < 3; k++) begin
                int len;
                len = $urandom_range(1, 8);
                send_clip(len);
                sent += len;
            end
        end
        // new rates mid-clip: held frame and phase carry over
        set_format(18'd22050, 18'd48000, 2'd2, 2'd2);
        send_frame(16'sh0100, 16'sh0200, 1'b0);
        send_frame(16'sh0300, 16'sh0400, 1'b0);
        set_format(18'd32000, 18'd16000, 2'd2, 2'd2);
        send_frame(16'sh0500, 16'sh0600, 1'b1);
    endtask

    // Receiver stalls while frames keep coming, then sender waits.
    task automatic test_backpressure();
        set_format(18'd8000, 18'd192000, 2'd2, 2'd2);
        hold_sink = 1'b1;
        fork
            begin
                repeat (600) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            send_clip(5);
        join
        drain();
        send_clip(4);
    endtask

    initial begin
        cfg_in_rate = RateReset;
        cfg_out_rate = RateReset;
        cfg_in_ch = ChReset;
        cfg_out_ch = ChReset;
        clear_clip();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random(400);
        // last stretch runs without gaps
        idle_on = 1'b0;
        test_random(40);
        drain();
        $display("covered %0d frames in %0d clips, %0d device frames checked",
                 n_items, n_clips, n_results);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
